FILE: rtl/utbd_pkg.sv
package utbd_pkg;

    localparam logic [6:0] DIGIT_ZERO   = 7'd48;
    localparam logic [6:0] LETTER_BASE  = 7'd65;
    localparam logic [5:0] LETTER_START = 6'd10;
    localparam logic [5:0] RADIX_MIN    = 6'd2;
    localparam logic [5:0] RADIX_MAX    = 6'd36;

    typedef struct packed {
        logic busy;
        logic done;
        logic nonzero;
    } t_div_stat;

    function automatic logic [6:0] digit_to_ascii(input logic [5:0] d);
        logic [6:0] ch;
        if (d < LETTER_START) begin
            ch = DIGIT_ZERO + 7'(d);
        end else begin
            ch = LETTER_BASE + 7'(d - LETTER_START);
        end
        return ch;
    endfunction

endpackage

FILE: rtl/utbd_div.sv
module utbd_div import utbd_pkg::*; #(
    parameter int VALUE_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [5:0]            i_radix,
    output logic [VALUE_BITS-1:0] o_quotient,
    output logic [5:0]            o_remainder,
    output t_div_stat             o_stat
);

    localparam int CW = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] r_work;
    logic [5:0]            r_rem;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic                  r_nz;

    logic [6:0] trial;
    logic       q_bit;
    logic [5:0] n_rem;

    // Restoring division, one dividend bit per cycle. The quotient bits
    // shift into the bottom of the working register as the dividend leaves.
    always_comb begin
        trial = {r_rem, r_work[VALUE_BITS-1]};
        q_bit = (trial >= {1'b0, i_radix});
        if (q_bit) begin
            n_rem = 6'(trial - {1'b0, i_radix});
        end else begin
            n_rem = trial[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
            r_cnt  <= CW'(VALUE_BITS - 1);
            r_nz   <= 1'b0;
        end else if (r_busy) begin
            r_work <= {r_work[VALUE_BITS-2:0], q_bit};
            r_rem  <= n_rem;
            r_cnt  <= r_cnt - 1'b1;
            r_nz   <= r_nz | q_bit;
        end
    end

    assign o_quotient     = r_work;
    assign o_remainder    = r_rem;
    assign o_stat.busy    = r_busy;
    assign o_stat.done    = r_done;
    assign o_stat.nonzero = r_nz;

endmodule

FILE: rtl/uint_to_base_digits.sv
// Converts an unsigned value to ASCII digits in a radix from 2 to 36, most
// significant digit first, one output beat per digit; the last beat carries
// the last mark and the digit count. A radix outside 2..36 gives a single
// beat with bad_base set. Digits come least significant first out of a
// bit-serial divider and are written to the digit store, then replayed
// from it most significant first through the read, load and output
// states, where each beat waits for the output to be taken. With the
// default sizes a worst-case item has 64 binary digits. One item is
// handled at a time; the input is ready only while the block is idle.
module uint_to_base_digits import utbd_pkg::*; #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_value,
    input  logic [5:0]  i_base,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [6:0]  o_digit_char,
    output logic        o_is_last,
    output logic [6:0]  o_digit_count,
    output logic        o_bad_base
);

    localparam int AW  = $clog2(MAX_DIGITS);
    localparam int CNW = $clog2(MAX_DIGITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_LOAD,
        S_OUT
    } t_state;

    t_state                r_state;
    logic                  r_div_start;
    logic [VALUE_BITS-1:0] r_div_value;
    logic [5:0]            r_radix;
    logic [CNW-1:0]        r_n;
    logic [AW-1:0]         r_rd_addr;
    logic [5:0]            r_rd_data;
    logic                  r_out_valid;
    logic [6:0]            r_out_char;
    logic                  r_out_last;
    logic [6:0]            r_out_count;
    logic                  r_out_bad;

    logic [5:0]            mem [MAX_DIGITS];

    logic [VALUE_BITS-1:0] div_quot;
    logic [5:0]            div_rem;
    t_div_stat             div_stat;
    logic                  base_bad;
    logic                  digit_wr;

    utbd_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_start),
        .i_dividend  (r_div_value),
        .i_radix     (r_radix),
        .o_quotient  (div_quot),
        .o_remainder (div_rem),
        .o_stat      (div_stat)
    );

    assign base_bad = (i_base < RADIX_MIN) || (i_base > RADIX_MAX);
    assign digit_wr = (r_state == S_DIV) && div_stat.done;

    always_ff @(posedge i_clk) begin
        if (digit_wr) begin
            mem[r_n[AW-1:0]] <= div_rem;
        end
        r_rd_data <= mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_radix     <= i_base;
                        r_div_value <= i_value[VALUE_BITS-1:0];
                        r_n         <= '0;
                        if (base_bad) begin
                            r_out_valid <= 1'b1;
                            r_out_char  <= '0;
                            r_out_last  <= 1'b1;
                            r_out_count <= '0;
                            r_out_bad   <= 1'b1;
                            r_state     <= S_OUT;
                        end else begin
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_n <= r_n + 1'b1;
                        // Keep dividing while the quotient is nonzero and the
                        // store still has room.
                        if (div_stat.nonzero && r_n != CNW'(MAX_DIGITS - 1)) begin
                            r_div_value <= div_quot;
                            r_div_start <= 1'b1;
                        end else begin
                            r_rd_addr <= r_n[AW-1:0];
                            r_state   <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_out_valid <= 1'b1;
                    r_out_char  <= digit_to_ascii(r_rd_data);
                    r_out_last  <= (r_rd_addr == '0);
                    r_out_count <= (r_rd_addr == '0) ? 7'(r_n) : 7'd0;
                    r_out_bad   <= 1'b0;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_rd_addr <= r_rd_addr - 1'b1;
                            r_state   <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_digit_char  = r_out_char;
    assign o_is_last     = r_out_last;
    assign o_digit_count = r_out_count;
    assign o_bad_base    = r_out_bad;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while an output beat is pending");

    a_bad_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_base) |-> (o_is_last && o_digit_count == 7'd0
            && o_digit_char == 7'd0))
        else $error("bad radix beat is malformed");

    a_count_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_last) |-> (o_digit_count == 7'd0))
        else $error("digit count on a beat that is not last");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");
`endif

endmodule
